// ===== sv/r2y_pkg.sv =====
// Shared types, widths, register codes and BT.601 coefficients for the RGB555 to YUY2 packer.
package r2y_pkg;

  localparam int unsigned PixW  = 15;
  localparam int unsigned ChanW = 5;
  localparam int unsigned CompW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 25;

  // Coefficient magnitudes; signs are applied in the sums
  localparam logic [SumW-1:0] YR   = 25'd8453;
  localparam logic [SumW-1:0] YG   = 25'd16594;
  localparam logic [SumW-1:0] YB   = 25'd3223;
  localparam logic [SumW-1:0] YOff = 25'd524288;
  localparam logic [SumW-1:0] UR   = 25'd4878;
  localparam logic [SumW-1:0] UG   = 25'd9578;
  localparam logic [SumW-1:0] UB   = 25'd14456;
  localparam logic [SumW-1:0] COff = 25'd4210688;
  localparam logic [SumW-1:0] VR   = 25'd14456;
  localparam logic [SumW-1:0] VG   = 25'd12105;
  localparam logic [SumW-1:0] VB   = 25'd2351;

  typedef enum logic [0:0] {
    REG_PACK_MODE  = 1'b0,
    REG_BYTE_ORDER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CompW-1:0] y;
    logic [CompW-1:0] u;
    logic [CompW-1:0] v;
  } yuv_t;

endpackage

// ===== sv/r2y_pix_if.sv =====
// Input channel carrying one RGB555 pixel pair per request.
interface r2y_pix_if import r2y_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_first;
  logic [PixW-1:0] pixel_second;

  modport source (output valid, output pixel_first, output pixel_second, input ready);
  modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

// ===== sv/r2y_word_if.sv =====
// Output channel carrying one packed YUYV word per request.
interface r2y_word_if import r2y_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] packed_word;
  logic             last_word;

  modport source (output valid, output packed_word, output last_word, input ready);
  modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface

// ===== sv/r2y_convert.sv =====
// Combinational RGB555 to Y/U/V conversion of one pixel.
module r2y_convert import r2y_pkg::*; (
  input  logic [PixW-1:0] pixel_i,
  output yuv_t            yuv_o
);

  logic [ChanW-1:0] r5, g5, b5;
  logic [CompW-1:0] r8, g8, b8;
  logic [SumW-1:0]  ys, us, vs;

  assign r5 = pixel_i[14:10];
  assign g5 = pixel_i[9:5];
  assign b5 = pixel_i[4:0];

  // Widen by replicating the top bits into the low bits
  assign r8 = {r5, r5[4:2]};
  assign g8 = {g5, g5[4:2]};
  assign b8 = {b5, b5[4:2]};

  // The true sums are positive and below 2**23, so modular math is exact
  assign ys = YR * SumW'(r8) + YG * SumW'(g8) + YB * SumW'(b8) + YOff;
  assign us = COff + UB * SumW'(b8) - UR * SumW'(r8) - UG * SumW'(g8);
  assign vs = COff + VR * SumW'(r8) - VG * SumW'(g8) - VB * SumW'(b8);

  assign yuv_o.y = ys[22:15];
  assign yuv_o.u = us[22:15];
  assign yuv_o.v = vs[22:15];

endmodule

// ===== sv/rgb555_to_yuy2_packer_unit.sv =====
// Top level: RGB555 pixel pair to YUY2 word packer with APB register port.
// Path: the first word of a pair passes through stage A, stage B and the output register to word_o.
// Throughput: one pair per cycle in pair mode while word_o.ready holds, two words per pair in doubled mode,
// set by the single-word output register that emits one word per cycle unless word_o stalls.
// Reset: rst_ni clears all stage valid bits, the word phase and both registers to zero.
module rgb555_to_yuy2_packer_unit import r2y_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  r2y_pix_if.sink          pix_i,
  r2y_word_if.source       word_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Word-aligned decode: paddr[2] selects the register.
  // ---------------------------------------------------------------------------
  logic     pack_mode_q, byte_order_q;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_mode_q  <= 1'b0;
      byte_order_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PACK_MODE:  pack_mode_q  <= pwdata[0];
        REG_BYTE_ORDER: byte_order_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PACK_MODE:  prdata = {{(DataW-1){1'b0}}, pack_mode_q};
      REG_BYTE_ORDER: prdata = {{(DataW-1){1'b0}}, byte_order_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage A holds the raw pixels, stage B the converted
  // components, and the output register the word on offer. Each stage advances
  // as soon as the one after it frees up, so in pair mode requests flow back to back.
  // ---------------------------------------------------------------------------
  logic valid_a_q, valid_b_q, out_valid_q, phase_q;
  logic load_out, b_done, b_free;

  // The output register takes a new word when empty or when its word is taken
  assign load_out = !out_valid_q || word_o.ready;
  // Stage B is finished once its last word moves into the output register;
  // doubled mode needs a second pass, tracked by phase_q
  assign b_done   = valid_b_q && load_out && (!pack_mode_q || phase_q);
  assign b_free   = !valid_b_q || b_done;

  assign pix_i.ready = !valid_a_q || b_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      valid_b_q   <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (pix_i.ready) valid_a_q <= pix_i.valid;
      if (b_free)      valid_b_q <= valid_a_q;
      if (load_out)    out_valid_q <= valid_b_q;
      // Advance to the second word of a doubled pair, drop back once it is loaded
      if (valid_b_q && load_out) phase_q <= pack_mode_q && !phase_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: capture the pixel pair.
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] px1_q, px2_q;

  always_ff @(posedge clk_i) begin
    if (pix_i.ready && pix_i.valid) begin
      px1_q <= pix_i.pixel_first;
      px2_q <= pix_i.pixel_second;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: BT.601 conversion of both pixels, registered.
  // ---------------------------------------------------------------------------
  yuv_t yuv1, yuv2, yuv1_q, yuv2_q;

  r2y_convert u_conv_first  (.pixel_i(px1_q), .yuv_o(yuv1));
  r2y_convert u_conv_second (.pixel_i(px2_q), .yuv_o(yuv2));

  always_ff @(posedge clk_i) begin
    if (b_free && valid_a_q) begin
      yuv1_q <= yuv1;
      yuv2_q <= yuv2;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: merge chroma or pick one pixel, then place the bytes.
  // ---------------------------------------------------------------------------
  logic [CompW:0]   u_sum, v_sum;
  logic [CompW-1:0] w_y1, w_y2, w_u, w_v;
  logic [WordW-1:0] word_d, word_q;
  logic             last_d, last_q;
  yuv_t             pick;

  assign u_sum = {1'b0, yuv1_q.u} + {1'b0, yuv2_q.u};
  assign v_sum = {1'b0, yuv1_q.v} + {1'b0, yuv2_q.v};
  assign pick  = phase_q ? yuv2_q : yuv1_q;

  always_comb begin
    if (pack_mode_q) begin
      // Doubled mode: each pixel fills both luma slots of its own word
      w_y1   = pick.y;
      w_y2   = pick.y;
      w_u    = pick.u;
      w_v    = pick.v;
      last_d = phase_q;
    end else begin
      w_y1   = yuv1_q.y;
      w_y2   = yuv2_q.y;
      w_u    = u_sum[CompW:1];
      // Big-endian order truncates each V before the sum
      w_v    = byte_order_q ? ({1'b0, yuv1_q.v[CompW-1:1]} + {1'b0, yuv2_q.v[CompW-1:1]})
                            : v_sum[CompW:1];
      last_d = 1'b1;
    end
    word_d = byte_order_q ? {w_y1, w_u, w_y2, w_v} : {w_v, w_y2, w_u, w_y1};
  end

  always_ff @(posedge clk_i) begin
    if (load_out && valid_b_q) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign word_o.valid       = out_valid_q;
  assign word_o.packed_word = word_q;
  assign word_o.last_word   = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_phase_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (valid_b_q && pack_mode_q))
    else $error("second-word phase set without a doubled pair in stage B");

  a_phase_word_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> out_valid_q)
    else $error("second-word phase set but first word not on offer");

  a_pair_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pack_mode_q) |-> last_q)
    else $error("pair-mode word without last_word");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && word_o.ready && !last_q) |=> (out_valid_q && last_q))
    else $error("first doubled word not followed by its second word");

endmodule
